// ===== rtl/lvc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lvc_pkg
// Shared types, constants and helpers of the line viewport clipper.
// ----------------------------------------------------------------------------
package lvc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int SCREEN_MAX = 4096;
  localparam int PIX_SHIFT  = 2 * FRAC_BITS;
  localparam int CAP_BITS   = 34;               // crossing offset saturates at 2^34
  localparam int DIV_STEPS  = CAP_BITS + 1;     // quotient bits below the cap
  localparam int DIV_LAT    = DIV_STEPS + 3;    // product, overflow check, steps, result
  localparam int PIX_W      = 13;

  typedef enum logic [2:0] {
    REG_VIEW_X_LOW,
    REG_VIEW_X_HIGH,
    REG_VIEW_Y_LOW,
    REG_VIEW_Y_HIGH,
    REG_SCREEN_WIDTH,
    REG_SCREEN_HEIGHT,
    REG_PPU_X,
    REG_PPU_Y
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] n_top;
    logic signed [32:0] n_bot;
    logic signed [32:0] n_rt;
    logic signed [32:0] n_lf;
  } side_t;

  typedef struct packed {
    logic [PIX_W-1:0]   px;
    logic [PIX_W-1:0]   py;
    logic signed [32:0] tn;
    logic [31:0]        td;
  } hit_t;

  // magnitude of a difference of two 32-bit values, always below 2^32
  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

  function automatic logic [PIX_W-1:0] pix_sat(input logic [31:0] p);
    return (p > 32'(SCREEN_MAX)) ? PIX_W'(SCREEN_MAX) : p[PIX_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lvc_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lvc_div
// Pipelined num * oth / den, truncated toward zero, saturated to +-2^34.
// One restoring step per stage; every stage advances only while en is high.
// ----------------------------------------------------------------------------
module lvc_div (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [32:0] num,
  input  wire logic signed [32:0] oth,
  input  wire logic signed [32:0] den,
  output      logic signed [35:0] q
);

  localparam int N = lvc_pkg::DIV_STEPS;

  logic [63:0] pm;
  logic [31:0] dm;
  logic        neg;

  logic [31:0]  rem [0:N];
  logic [N-1:0] low [0:N];
  logic [N-1:0] qq  [0:N];
  logic [31:0]  dd  [0:N];
  logic         ng  [0:N];
  logic         st  [0:N];

  logic [N-1:0] mg;
  logic [35:0]  mg36;

  always_ff @(posedge clk) begin
    if (en) begin
      pm  <= 64'(lvc_pkg::mag33(num)) * 64'(lvc_pkg::mag33(oth));
      dm  <= lvc_pkg::mag33(den);
      neg <= num[32] ^ oth[32] ^ den[32];
    end
  end

  // quotient above the cap when pm >= (2^34 + 1) * dm
  always_ff @(posedge clk) begin
    if (en) begin
      st[0]  <= {3'b0, pm} >= ({1'b0, dm, {lvc_pkg::CAP_BITS{1'b0}}} + 67'(dm));
      rem[0] <= 32'(pm[63:N]);
      low[0] <= pm[N-1:0];
      qq[0]  <= '0;
      dd[0]  <= dm;
      ng[0]  <= neg;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_step
    logic [32:0] t;
    logic [32:0] sub;
    logic        ge;
    assign t   = {rem[j], low[j][N-1]};
    assign sub = t - {1'b0, dd[j]};
    assign ge  = t >= {1'b0, dd[j]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= ge ? sub[31:0] : t[31:0];
        low[j+1] <= {low[j][N-2:0], 1'b0};
        qq[j+1]  <= {qq[j][N-2:0], ge};
        dd[j+1]  <= dd[j];
        ng[j+1]  <= ng[j];
        st[j+1]  <= st[j];
      end
    end
  end

  assign mg   = st[N] ? (N'(1) << lvc_pkg::CAP_BITS) : qq[N];
  assign mg36 = 36'(mg);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= ng[N] ? $signed(36'(-mg36)) : $signed(mg36);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/line_viewport_clip.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// line_viewport_clip
// Clips an infinite line through two Q16.16 points against a viewport.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one line per beat: tdata holds first_point_x, first_point_y,
//   second_point_x, second_point_y, 32 bits each from the low bits up.
//   m_axis returns one result beat per line: start/end pixel pairs, the edge
//   hit count and the visible flag.
//   cfg writes one viewport/screen register per beat (cfg_index, cfg_data);
//   write only while no line is in flight. cfg_ready is always high.
// Timing:
//   Each result passes stage 0, the 35-step pipelined divider per edge and
//   stages A to E. One line is accepted every cycle unless m_axis stalls.
// Reset: registers take their default viewport, pipeline empties.
// Stall: while a result waits on m_axis_tready the whole pipeline holds and
//   s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module line_viewport_clip (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // first_point_x, first_point_y, second_point_x, second_point_y
  input  wire logic [127:0] s_axis_tdata,
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // start_pixel_x, start_pixel_y, end_pixel_x, end_pixel_y, edge_hits, visible
  output      logic [55:0]  m_axis_tdata,
  input  wire logic         cfg_valid,
  output      logic         cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  localparam int PW = lvc_pkg::PIX_W;
  localparam int DL = lvc_pkg::DIV_LAT;

  logic signed [31:0] xl, xh, yl, yh;
  logic [PW-1:0]      scr_w, scr_h;
  logic [31:0]        ppu_x, ppu_y;
  logic               en;

  assign cfg_ready     = 1'b1;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      xl    <= '0;
      xh    <= 32'sd65536;
      yl    <= '0;
      yh    <= 32'sd65536;
      scr_w <= PW'(640);
      scr_h <= PW'(480);
      ppu_x <= 32'd65536;
      ppu_y <= 32'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (lvc_pkg::reg_idx_t'(cfg_index))
        lvc_pkg::REG_VIEW_X_LOW:    xl    <= cfg_data;
        lvc_pkg::REG_VIEW_X_HIGH:   xh    <= cfg_data;
        lvc_pkg::REG_VIEW_Y_LOW:    yl    <= cfg_data;
        lvc_pkg::REG_VIEW_Y_HIGH:   yh    <= cfg_data;
        lvc_pkg::REG_SCREEN_WIDTH:  scr_w <= cfg_data[PW-1:0];
        lvc_pkg::REG_SCREEN_HEIGHT: scr_h <= cfg_data[PW-1:0];
        lvc_pkg::REG_PPU_X:         ppu_x <= cfg_data;
        lvc_pkg::REG_PPU_Y:         ppu_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- stage 0: differences
  logic               v0;
  lvc_pkg::side_t     s0;
  logic signed [31:0] ax_in, ay_in, bx_in, by_in;

  assign ax_in = s_axis_tdata[31:0];
  assign ay_in = s_axis_tdata[63:32];
  assign bx_in = s_axis_tdata[95:64];
  assign by_in = s_axis_tdata[127:96];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0.ax    <= ax_in;
      s0.ay    <= ay_in;
      s0.dx    <= 33'(bx_in) - 33'(ax_in);
      s0.dy    <= 33'(by_in) - 33'(ay_in);
      s0.n_top <= 33'(yh) - 33'(ay_in);
      s0.n_bot <= 33'(yl) - 33'(ay_in);
      s0.n_rt  <= 33'(xh) - 33'(ax_in);
      s0.n_lf  <= 33'(xl) - 33'(ax_in);
    end
  end

  // ---- dividers, one per edge: top, bottom, right, left
  logic signed [35:0] q_top, q_bot, q_rt, q_lf;

  lvc_div u_div_top (.clk, .en, .num(s0.n_top), .oth(s0.dx), .den(s0.dy), .q(q_top));
  lvc_div u_div_bot (.clk, .en, .num(s0.n_bot), .oth(s0.dx), .den(s0.dy), .q(q_bot));
  lvc_div u_div_rt  (.clk, .en, .num(s0.n_rt),  .oth(s0.dy), .den(s0.dx), .q(q_rt));
  lvc_div u_div_lf  (.clk, .en, .num(s0.n_lf),  .oth(s0.dy), .den(s0.dx), .q(q_lf));

  // side data rides alongside the dividers
  logic [DL-1:0]  vd;
  lvc_pkg::side_t sd [0:DL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else if (en) begin
      vd <= {vd[DL-2:0], v0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= s0;
      for (int k = 1; k < DL; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  // ---- stage A: crossings, span test, offsets into span
  lvc_pkg::side_t     sa;
  logic signed [35:0] xl36, xh36, yl36, yh36;
  logic signed [35:0] c [0:3];
  logic [3:0]         hv_c;

  assign sa   = sd[DL-1];
  assign xl36 = 36'(xl);
  assign xh36 = 36'(xh);
  assign yl36 = 36'(yl);
  assign yh36 = 36'(yh);
  assign c[0] = 36'(sa.ax) + q_top;
  assign c[1] = 36'(sa.ax) + q_bot;
  assign c[2] = 36'(sa.ay) + q_rt;
  assign c[3] = 36'(sa.ay) + q_lf;

  assign hv_c[0] = (sa.dy != '0) && (xl36 <= c[0]) && (c[0] <= xh36);
  assign hv_c[1] = (sa.dy != '0) && (xl36 <= c[1]) && (c[1] <= xh36);
  assign hv_c[2] = (sa.dx != '0) && (yl36 <= c[2]) && (c[2] <= yh36);
  assign hv_c[3] = (sa.dx != '0) && (yl36 <= c[3]) && (c[3] <= yh36);

  logic               va;
  logic [3:0]         hva;
  logic [31:0]        da [0:3];
  logic signed [32:0] tna [0:3];
  logic [31:0]        tda [0:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= vd[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hva    <= hv_c;
      da[0]  <= 32'(c[0] - xl36);
      da[1]  <= 32'(c[1] - xl36);
      da[2]  <= 32'(c[2] - yl36);
      da[3]  <= 32'(c[3] - yl36);
      tna[0] <= sa.dy[32] ? -sa.n_top : sa.n_top;
      tna[1] <= sa.dy[32] ? -sa.n_bot : sa.n_bot;
      tna[2] <= sa.dx[32] ? -sa.n_rt  : sa.n_rt;
      tna[3] <= sa.dx[32] ? -sa.n_lf  : sa.n_lf;
      tda[0] <= lvc_pkg::mag33(sa.dy);
      tda[1] <= lvc_pkg::mag33(sa.dy);
      tda[2] <= lvc_pkg::mag33(sa.dx);
      tda[3] <= lvc_pkg::mag33(sa.dx);
    end
  end

  // ---- stage B: scale to pixels
  logic               vb;
  logic [3:0]         hvb;
  logic [31:0]        pb [0:3];
  logic signed [32:0] tnb [0:3];
  logic [31:0]        tdb [0:3];
  logic [63:0]        pr [0:3];

  assign pr[0] = 64'(da[0]) * 64'(ppu_x);
  assign pr[1] = 64'(da[1]) * 64'(ppu_x);
  assign pr[2] = 64'(da[2]) * 64'(ppu_y);
  assign pr[3] = 64'(da[3]) * 64'(ppu_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hvb <= hva;
      for (int i = 0; i < 4; i++) begin
        pb[i]  <= 32'(pr[i] >> lvc_pkg::PIX_SHIFT);
        tnb[i] <= tna[i];
        tdb[i] <= tda[i];
      end
    end
  end

  // ---- stage C: pick the first two hits in edge order
  lvc_pkg::hit_t cand [0:3];
  lvc_pkg::hit_t h0_c, h1_c;
  logic [2:0]    cnt_c;
  logic [PW-1:0] pin_w, pin_h;

  assign pin_w = lvc_pkg::pix_sat(32'(scr_w));
  assign pin_h = lvc_pkg::pix_sat(32'(scr_h));

  always_comb begin
    cand[0] = '{px: lvc_pkg::pix_sat(pb[0]), py: pin_h, tn: tnb[0], td: tdb[0]};
    cand[1] = '{px: lvc_pkg::pix_sat(pb[1]), py: '0,    tn: tnb[1], td: tdb[1]};
    cand[2] = '{px: pin_w, py: lvc_pkg::pix_sat(pb[2]), tn: tnb[2], td: tdb[2]};
    cand[3] = '{px: '0,    py: lvc_pkg::pix_sat(pb[3]), tn: tnb[3], td: tdb[3]};
    h0_c  = '0;
    h1_c  = '0;
    cnt_c = '0;
    for (int i = 0; i < 4; i++) begin
      if (hvb[i]) begin
        if (cnt_c == 3'd0) begin
          h0_c = cand[i];
        end else if (cnt_c == 3'd1) begin
          h1_c = cand[i];
        end
        cnt_c = cnt_c + 3'd1;
      end
    end
  end

  logic          vc;
  lvc_pkg::hit_t h0c, h1c;
  logic [2:0]    cntc;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h0c  <= h0_c;
      h1c  <= h1_c;
      cntc <= cnt_c;
    end
  end

  // ---- stage D: cross products for the parameter compare
  logic          vdd;
  lvc_pkg::hit_t h0d, h1d;
  logic [2:0]    cntd;
  logic [63:0]   m1, m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vdd <= 1'b0;
    end else if (en) begin
      vdd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h0d  <= h0c;
      h1d  <= h1c;
      cntd <= cntc;
      m1   <= 64'(lvc_pkg::mag33(h0c.tn)) * 64'(h1c.td);
      m2   <= 64'(lvc_pkg::mag33(h1c.tn)) * 64'(h0c.td);
    end
  end

  // ---- stage E: order the pair, output register
  logic          le, swap;
  lvc_pkg::hit_t hs, he;

  always_comb begin
    if (h0d.tn[32] && !h1d.tn[32]) begin
      le = 1'b1;
    end else if (!h0d.tn[32] && h1d.tn[32]) begin
      le = 1'b0;
    end else if (!h0d.tn[32]) begin
      le = m1 <= m2;
    end else begin
      le = m1 >= m2;
    end
    swap = (cntd >= 3'd2) && !le;
    hs   = swap ? h1d : h0d;
    he   = swap ? h0d : h1d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= vdd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {cntd >= 3'd2, cntd, he.py, he.px, hs.py, hs.px};
    end
  end

`ifndef SYNTHESIS
  a_vis_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[55] == (m_axis_tdata[54:52] >= 3'd2)))
    else $error("visible flag disagrees with hit count");

  a_hits_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[54:52] <= 3'd4))
    else $error("more than four edge hits");

  a_no_end: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[54:52] < 3'd2) |-> (m_axis_tdata[51:26] == '0))
    else $error("end pixel set without a second hit");

  a_no_start: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[54:52] == 3'd0) |-> (m_axis_tdata[25:0] == '0))
    else $error("start pixel set without any hit");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while result stalls");
`endif

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for line_viewport_clip. Lines stream in over s_axis
// with random gaps. Results on m_axis are checked against a line-clip
// predictor kept in lockstep with the configuration writes. A short directed
// table comes first, then random and fixed corner-case viewports with mostly
// near-viewport lines, and one long output hold-off to fill the pipeline.
// ----------------------------------------------------------------------------
module testbench;

  localparam longint CAP        = 64'sd1 <<< 34;
  localparam int     WATCH_MAX  = 3000;
  localparam int     HOLD_LEN   = 400;
  localparam int     DRAIN_WAIT = 60;
  localparam int     PHASES     = 6;
  localparam int     PER_PHASE  = 173;

  typedef struct packed {
    logic [12:0] sx;
    logic [12:0] sy;
    logic [12:0] ex;
    logic [12:0] ey;
    logic [2:0]  hits;
    logic        vis;
  } clip_res_t;

  typedef struct {
    int        fx, fy, sx, sy;
    bit        typed;
    clip_res_t res;
  } stim_row_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [55:0]  m_axis_tdata;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  line_viewport_clip uut (.*);

  always #4 clk = ~clk;

  // predictor copy of the registers
  longint unsigned view_regs [8];
  clip_res_t       clip_expected [$];
  int              errors = 0;
  bit              idle_on = 1;
  bit              hold_pending = 0;
  int              idle_cycles = 0;

  function automatic longint unsigned absval(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint sx32(longint unsigned v);
    return longint'(int'(v[31:0]));
  endfunction

  // num*oth/den truncated toward zero, saturated at +-2^34
  function automatic longint cross_offset(longint num, longint oth, longint den);
    bit         neg;
    logic [127:0] q;
    neg = ((num < 0) != (oth < 0)) != (den < 0);
    q = (128'(absval(num)) * 128'(absval(oth))) / 128'(absval(den));
    if (q > 128'(CAP)) q = 128'(CAP);
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic [12:0] screen_pixel(longint c, longint lo, longint unsigned ppu);
    logic [63:0] p;
    p = 64'(c - lo) * 64'(ppu);
    p = p >> lvc_pkg::PIX_SHIFT;
    return p > 64'(lvc_pkg::SCREEN_MAX) ? 13'(lvc_pkg::SCREEN_MAX) : 13'(p);
  endfunction

  function automatic logic [12:0] pinned(longint unsigned size);
    return size > lvc_pkg::SCREEN_MAX ? 13'(lvc_pkg::SCREEN_MAX) : 13'(size);
  endfunction

  function automatic clip_res_t clip_line(int fx, int fy, int sx, int sy);
    longint xl, xh, yl, yh, ax, ay, dx, dy, num, den, c, lo, hi;
    logic [12:0] px [2];
    logic [12:0] py [2];
    longint tn [2];
    longint td [2];
    logic [12:0] hx, hy, tmp13;
    longint tmp;
    logic signed [127:0] lhs, rhs;
    int count;
    clip_res_t r;
    xl = sx32(view_regs[0]); xh = sx32(view_regs[1]);
    yl = sx32(view_regs[2]); yh = sx32(view_regs[3]);
    ax = fx; ay = fy; dx = longint'(sx) - ax; dy = longint'(sy) - ay;
    count = 0;
    for (int i = 0; i < 2; i++) begin
      px[i] = 0; py[i] = 0; tn[i] = 0; td[i] = 0;
    end
    // edges in order top, bottom, right, left
    for (int e = 0; e < 4; e++) begin
      if (e < 2) begin
        den = dy;
        num = (e == 0 ? yh : yl) - ay;
        lo = xl; hi = xh;
      end else begin
        den = dx;
        num = (e == 2 ? xh : xl) - ax;
        lo = yl; hi = yh;
      end
      if (den != 0) begin
        c = (e < 2 ? ax : ay) + cross_offset(num, e < 2 ? dx : dy, den);
        if (lo <= c && c <= hi) begin
          case (e)
            0: begin hx = screen_pixel(c, xl, view_regs[6]); hy = pinned(view_regs[5]); end
            1: begin hx = screen_pixel(c, xl, view_regs[6]); hy = 0; end
            2: begin hx = pinned(view_regs[4]); hy = screen_pixel(c, yl, view_regs[7]); end
            default: begin hx = 0; hy = screen_pixel(c, yl, view_regs[7]); end
          endcase
          if (count < 2) begin
            px[count] = hx; py[count] = hy;
            tn[count] = den < 0 ? -num : num;
            td[count] = den < 0 ? -den : den;
          end
          count++;
        end
      end
    end
    if (count >= 2) begin
      lhs = 128'(signed'(tn[0])) * 128'(signed'(td[1]));
      rhs = 128'(signed'(tn[1])) * 128'(signed'(td[0]));
      if (lhs > rhs) begin
        tmp13 = px[0]; px[0] = px[1]; px[1] = tmp13;
        tmp13 = py[0]; py[0] = py[1]; py[1] = tmp13;
        tmp = tn[0]; tn[0] = tn[1]; tn[1] = tmp;
      end
    end
    r.sx = px[0]; r.sy = py[0]; r.ex = px[1]; r.ey = py[1];
    r.hits = 3'(count);
    r.vis = count >= 2;
    return r;
  endfunction

  task automatic check_field(string name, logic [12:0] want, logic [12:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // result checker; tdata carries start_pixel_x in the lowest bits
  always @(posedge clk) begin
    clip_res_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.sx   = m_axis_tdata[12:0];
      got.sy   = m_axis_tdata[25:13];
      got.ex   = m_axis_tdata[38:26];
      got.ey   = m_axis_tdata[51:39];
      got.hits = m_axis_tdata[54:52];
      got.vis  = m_axis_tdata[55];
      if (clip_expected.size() == 0) begin
        $display("%0t unexpected result beat: expected none actual %h", $time,
                 m_axis_tdata);
        errors++;
      end else begin
        want = clip_expected.pop_front();
        check_field("start_pixel_x", want.sx, got.sx);
        check_field("start_pixel_y", want.sy, got.sy);
        check_field("end_pixel_x", want.ex, got.ex);
        check_field("end_pixel_y", want.ey, got.ey);
        check_field("edge_hits", 13'(want.hits), 13'(got.hits));
        check_field("visible", 13'(want.vis), 13'(got.vis));
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_MAX) begin
      $display("testbench failed");
      $finish;
    end
  end

  // result receiver
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if (hold_pending) begin
        m_axis_tready <= 0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_pending = 0;
      end
      stall = idle_on ? $urandom_range(0, 18) : 0;
      if (stall > 0) begin
        m_axis_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  task automatic write_reg(lvc_pkg::reg_idx_t idx, logic [31:0] value);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    view_regs[idx] = (idx == lvc_pkg::REG_SCREEN_WIDTH ||
                      idx == lvc_pkg::REG_SCREEN_HEIGHT) ? value & 32'h1FFF : value;
  endtask

  task automatic send_line(int fx, int fy, int sx, int sy, bit typed, clip_res_t res);
    int gap;
    gap = idle_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {sy, sx, fy, fx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    clip_expected.push_back(typed ? res : clip_line(fx, fy, sx, sy));
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    while (clip_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // coordinate near [lo, hi], sometimes exactly on a bound
  function automatic int near_coord(longint lo, longint hi);
    longint w, v;
    w = absval(hi - lo) + 65536;
    case ($urandom_range(0, 7))
      0: v = lo;
      1: v = hi;
      default: v = lo - w / 2 + longint'({$urandom, $urandom} % (2 * w));
    endcase
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return int'(v);
  endfunction

  function automatic logic [31:0] rand_ppu;
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFFFFFF;
      2: return $urandom;
      default: return $urandom_range(32'h10000, 32'h4000000);
    endcase
  endfunction

  stim_row_t rows [$];

  initial begin
    int lo_x, lo_y, span;
    logic [31:0] vx_lo, vx_hi, vy_lo, vy_hi;
    rows = '{
      '{0, 32'h8000, 32'h10000, 32'h8000, 1, '{0, 0, 640, 0, 2, 1}},
      '{32'h8000, 0, 32'h8000, 32'h10000, 1, '{0, 0, 0, 480, 2, 1}},
      '{0, 0, 32'h10000, 32'h10000, 1, '{0, 0, 1, 480, 4, 1}},
      '{32'h4000, 32'h4000, 32'h4000, 32'h4000, 1, '{0, 0, 0, 0, 0, 0}},
      '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 0, '0},
      '{32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, '0},
      '{32'h80000000, 0, 32'h7FFFFFFF, 1, 0, '0},
      '{0, 32'h8000, 32'h7FFFFFFF, 32'h8001, 0, '0},
      '{32'h7FFF0000, 32'h7FFF0000, 32'h7FFF0001, 32'h7FFF0003, 0, '0},
      '{32'h10000, 32'h10000, 32'h20000, 32'h0, 0, '0},
      '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'h1, 32'h1, 0, '0},
      '{32'h0, 32'h10000, 32'h10000, 32'h0, 0, '0}
    };
    view_regs = '{0, 65536, 0, 65536, 640, 480, 65536, 65536};
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (rows[i])
      send_line(rows[i].fx, rows[i].fy, rows[i].sx, rows[i].sy, rows[i].typed, rows[i].res);
    drain();
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: begin
          // full signed span, widest screen, largest scale
          vx_lo = 32'h80000000; vx_hi = 32'h7FFFFFFF;
          vy_lo = 32'h80000000; vy_hi = 32'h7FFFFFFF;
        end
        2: begin
          // inverted x span
          vx_lo = 32'h30000; vx_hi = 32'h10000;
          vy_lo = 32'hFFFF0000; vy_hi = 32'h20000;
        end
        default: begin
          lo_x = $urandom_range(0, 32'h400000) - 32'h200000;
          lo_y = $urandom_range(0, 32'h400000) - 32'h200000;
          span = $urandom_range(1, 32'h100000);
          vx_lo = lo_x; vx_hi = lo_x + span;
          span = $urandom_range(1, 32'h100000);
          vy_lo = lo_y; vy_hi = lo_y + span;
          if (ph == 4) {vy_lo, vy_hi} = {vy_hi, vy_lo};
        end
      endcase
      write_reg(lvc_pkg::REG_VIEW_X_LOW, vx_lo);
      write_reg(lvc_pkg::REG_VIEW_X_HIGH, vx_hi);
      write_reg(lvc_pkg::REG_VIEW_Y_LOW, vy_lo);
      write_reg(lvc_pkg::REG_VIEW_Y_HIGH, vy_hi);
      write_reg(lvc_pkg::REG_SCREEN_WIDTH, ph == 1 ? 32'hFFFFFFFF : ph == 2 ? 32'h1 :
                                  $urandom_range(1, 4096) | ($urandom << 13));
      write_reg(lvc_pkg::REG_SCREEN_HEIGHT, ph == 1 ? 32'd4096 : ph == 2 ? 32'h1 :
                                   $urandom_range(1, 4096));
      write_reg(lvc_pkg::REG_PPU_X, ph == 1 ? 32'hFFFFFFFF : ph == 2 ? 32'h0 : rand_ppu());
      write_reg(lvc_pkg::REG_PPU_Y, ph == 1 ? 32'hFFFFFFFF : ph == 2 ? 32'h0 : rand_ppu());
      cfg_valid <= 0;
      idle_on = (ph != 3);
      if (ph == 0) begin
        // stall the output long enough to back the pipeline up
        hold_pending = 1;
        idle_on = 0;
      end
      for (int n = 0; n < PER_PHASE; n++) begin
        if (ph == 0 && n == 100) idle_on = 1;
        if ($urandom_range(0, 9) < 2)
          send_line($urandom, $urandom, $urandom, $urandom, 0, '0);
        else
          send_line(near_coord(sx32(view_regs[0]), sx32(view_regs[1])),
                    near_coord(sx32(view_regs[2]), sx32(view_regs[3])),
                    near_coord(sx32(view_regs[0]), sx32(view_regs[1])),
                    near_coord(sx32(view_regs[2]), sx32(view_regs[3])), 0, '0);
      end
      drain();
    end
    if (errors == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lvc_pkg.sv
rtl/lvc_div.sv
rtl/line_viewport_clip.sv
sim/testbench.sv
